>>> rtl/csa_pkg.sv
// Constants, codes and state type for the contiguous segment allocator.
// No dependencies.
`default_nettype none
package csa_pkg;
    localparam int MAX_SEG = 16;
    localparam int IDX_W   = $clog2(MAX_SEG);
    localparam int CNT_W   = IDX_W + 1;
    localparam int ADDR_W  = 20;
    localparam int OWN_W   = 8;
    localparam int SIZE_W  = ADDR_W + 1;

    localparam logic [SIZE_W-1:0] MEM_LIMIT = SIZE_W'(1) << ADDR_W;

    localparam logic [1:0] MODE_REQUEST = 2'd0;
    localparam logic [1:0] MODE_RELEASE = 2'd1;
    localparam logic [1:0] MODE_COMPACT = 2'd2;

    localparam logic [1:0] FIT_FIRST = 2'd0;
    localparam logic [1:0] FIT_BEST  = 2'd1;
    localparam logic [1:0] FIT_WORST = 2'd2;

    localparam logic [2:0] ST_OK          = 3'd0;
    localparam logic [2:0] ST_BAD_POLICY  = 3'd1;
    localparam logic [2:0] ST_NO_HOLE     = 3'd2;
    localparam logic [2:0] ST_NO_RELEASE  = 3'd3;
    localparam logic [2:0] ST_TABLE_FULL  = 3'd4;
    localparam logic [2:0] ST_BAD_SIZE    = 3'd5;

    typedef enum logic [8:0] {
        S_IDLE    = 9'b000000001,
        S_SCAN    = 9'b000000010,
        S_SHIFT   = 9'b000000100,
        S_SPLIT   = 9'b000001000,
        S_GRANT   = 9'b000010000,
        S_MERGE   = 9'b000100000,
        S_COMPACT = 9'b001000000,
        S_TAIL    = 9'b010000000,
        S_DONE    = 9'b100000000
    } seq_state_t;
endpackage
`default_nettype wire

>>> rtl/contiguous_segment_allocator.sv
// Contiguous segment allocator: segment table, sequencer and result register.
// Depends on csa_pkg.
`default_nettype none
// Usage:
//   s_axis carries one operation per item (request, release or compact).
//   m_axis returns exactly one result item per operation.
//   cfg_we with cfg_wdata sets the managed size and puts the table back to
//   one free segment; write it only while the block is idle.
// Flow:
//   One operation is worked on at a time; s_axis_tready is low meanwhile.
//   A request scans the table; if the hole is larger than asked it shifts
//   entries up to open a slot and writes the split-off free entry, then
//   writes the granted entry. A split needs a free slot. Release takes
//   one pass over the table; compact takes one pass plus the free tail.
//   Requests with a bad policy or size go straight to the result. The
//   table has a single read/write port, and one pass counter steps it.
// Reset:
//   rst_n clears the table to one free segment of 2^20 bytes.
// Stall:
//   A finished result holds in the output register until taken; the next
//   item is accepted meanwhile, and its result waits behind the first.
module contiguous_segment_allocator
    import csa_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [20:0] cfg_wdata,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // [1:0] mode, [9:2] owner_id, [30:10] request_size, [32:31] fit_policy
    input  wire logic [39:0] s_axis_tdata,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [2:0] status, [22:3] alloc_base, [27:23] segments_in_use
    output logic [31:0]      m_axis_tdata
);
    seq_state_t state_reg, state_next;

    logic [ADDR_W-1:0] seg_start_reg [MAX_SEG];
    logic [ADDR_W-1:0] seg_end_reg   [MAX_SEG];
    logic [OWN_W-1:0]  seg_owner_reg [MAX_SEG];
    logic [MAX_SEG-1:0] seg_used_reg;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [SIZE_W-1:0] mem_size_reg;

    logic [1:0]        mode_reg;
    logic [OWN_W-1:0]  own_reg;
    logic [SIZE_W-1:0] size_reg;
    logic [1:0]        pol_reg;

    logic [CNT_W-1:0]  idx_reg, idx_next;
    logic [CNT_W-1:0]  w_reg, w_next;
    logic [IDX_W-1:0]  pick_reg, pick_next;
    logic [ADDR_W-1:0] pick_start_reg, pick_start_next;
    logic [SIZE_W-1:0] best_reg, best_next;
    logic              found_reg, found_next;
    logic              prev_used_reg, prev_used_next;
    logic              freed_reg, freed_next;
    logic [SIZE_W-1:0] next_addr_reg, next_addr_next;
    logic [2:0]        res_status_reg, res_status_next;
    logic [ADDR_W-1:0] res_base_reg, res_base_next;

    logic              out_valid_reg;
    logic [2:0]        out_status_reg;
    logic [ADDR_W-1:0] out_base_reg;
    logic [CNT_W-1:0]  out_count_reg;

    logic [IDX_W-1:0]  rd_idx;
    logic [ADDR_W-1:0] rd_start, rd_end;
    logic [OWN_W-1:0]  rd_owner;
    logic              rd_used;
    logic [SIZE_W-1:0] rd_len;
    logic [ADDR_W-1:0] rd_span;

    logic              wr_se, wr_ee, wr_oe, wr_ue;
    logic [IDX_W-1:0]  wr_idx;
    logic [ADDR_W-1:0] wr_start, wr_end;
    logic [OWN_W-1:0]  wr_owner;
    logic              wr_used;

    logic              in_fire;
    logic              out_free;
    logic [SIZE_W-1:0] cfg_sat;
    logic              cand, take, u_eff;
    logic [CNT_W-1:0]  pick_ext;

    assign in_fire  = s_axis_tvalid && s_axis_tready;
    assign out_free = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {4'd0, out_count_reg, out_base_reg, out_status_reg};

    assign cfg_sat = (cfg_wdata == '0) ? SIZE_W'(1) :
                     (cfg_wdata > MEM_LIMIT) ? MEM_LIMIT : cfg_wdata;

    assign pick_ext = {1'b0, pick_reg};
    assign rd_idx   = (state_reg == S_SHIFT) ? IDX_W'(idx_reg - 1'b1) : idx_reg[IDX_W-1:0];
    assign rd_start = seg_start_reg[rd_idx];
    assign rd_end   = seg_end_reg[rd_idx];
    assign rd_owner = seg_owner_reg[rd_idx];
    assign rd_used  = seg_used_reg[rd_idx];
    assign rd_span  = rd_end - rd_start;
    assign rd_len   = {1'b0, rd_span} + SIZE_W'(1);

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        idx_next        = idx_reg;
        w_next          = w_reg;
        pick_next       = pick_reg;
        pick_start_next = pick_start_reg;
        best_next       = best_reg;
        found_next      = found_reg;
        prev_used_next  = prev_used_reg;
        freed_next      = freed_reg;
        next_addr_next  = next_addr_reg;
        res_status_next = res_status_reg;
        res_base_next   = res_base_reg;
        wr_se = 1'b0; wr_ee = 1'b0; wr_oe = 1'b0; wr_ue = 1'b0;
        wr_idx   = idx_reg[IDX_W-1:0];
        wr_start = rd_start;
        wr_end   = rd_end;
        wr_owner = rd_owner;
        wr_used  = rd_used;
        cand  = !rd_used && (rd_len >= size_reg);
        take  = 1'b0;
        u_eff = rd_used && (rd_owner != own_reg);
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    idx_next        = '0;
                    w_next          = '0;
                    found_next      = 1'b0;
                    freed_next      = 1'b0;
                    prev_used_next  = 1'b0;
                    next_addr_next  = '0;
                    res_status_next = ST_OK;
                    res_base_next   = '0;
                    unique case (s_axis_tdata[1:0])
                        MODE_REQUEST:
                        begin
                            if (s_axis_tdata[32:31] > FIT_WORST)
                            begin
                                res_status_next = ST_BAD_POLICY;
                                state_next      = S_DONE;
                            end
                            else if (s_axis_tdata[30:10] == '0)
                            begin
                                res_status_next = ST_BAD_SIZE;
                                state_next      = S_DONE;
                            end
                            else
                            begin
                                state_next = S_SCAN;
                            end
                        end
                        MODE_RELEASE: state_next = S_MERGE;
                        MODE_COMPACT: state_next = S_COMPACT;
                        default:      state_next = S_DONE;
                    endcase
                end
            end
            S_SCAN:
            begin
                if (idx_reg < count_reg)
                begin
                    priority if (pol_reg == FIT_FIRST)
                        take = cand && !found_reg;
                    else if (pol_reg == FIT_BEST)
                        take = cand && (!found_reg || rd_len < best_reg);
                    else
                        take = cand && (!found_reg || rd_len > best_reg);
                    if (take)
                    begin
                        found_next      = 1'b1;
                        pick_next       = idx_reg[IDX_W-1:0];
                        pick_start_next = rd_start;
                        best_next       = rd_len;
                    end
                    idx_next = idx_reg + 1'b1;
                end
                else if (!found_reg)
                begin
                    res_status_next = ST_NO_HOLE;
                    state_next      = S_DONE;
                end
                else if (best_reg != size_reg)
                begin
                    if (count_reg >= CNT_W'(MAX_SEG))
                    begin
                        res_status_next = ST_TABLE_FULL;
                        state_next      = S_DONE;
                    end
                    else
                    begin
                        idx_next   = count_reg;
                        state_next = S_SHIFT;
                    end
                end
                else
                begin
                    state_next = S_GRANT;
                end
            end
            S_SHIFT:
            begin
                if (idx_reg > pick_ext + 1'b1)
                begin
                    wr_se = 1'b1; wr_ee = 1'b1; wr_oe = 1'b1; wr_ue = 1'b1;
                    idx_next = idx_reg - 1'b1;
                end
                else
                begin
                    state_next = S_SPLIT;
                end
            end
            S_SPLIT:
            begin
                wr_se = 1'b1; wr_ee = 1'b1; wr_oe = 1'b1; wr_ue = 1'b1;
                wr_idx   = IDX_W'(pick_ext + 1'b1);
                wr_start = pick_start_reg + size_reg[ADDR_W-1:0];
                wr_end   = pick_start_reg + best_reg[ADDR_W-1:0] - 1'b1;
                wr_owner = '0;
                wr_used  = 1'b0;
                count_next = count_reg + 1'b1;
                state_next = S_GRANT;
            end
            S_GRANT:
            begin
                wr_ee = 1'b1; wr_oe = 1'b1; wr_ue = 1'b1;
                wr_idx   = pick_reg;
                wr_end   = pick_start_reg + size_reg[ADDR_W-1:0] - 1'b1;
                wr_owner = own_reg;
                wr_used  = 1'b1;
                res_status_next = ST_OK;
                res_base_next   = pick_start_reg;
                state_next      = S_DONE;
            end
            S_MERGE:
            begin
                if (idx_reg < count_reg)
                begin
                    if (rd_used && !u_eff)
                        freed_next = 1'b1;
                    if (w_reg != '0 && !u_eff && !prev_used_reg)
                    begin
                        wr_ee  = 1'b1;
                        wr_idx = IDX_W'(w_reg - 1'b1);
                    end
                    else
                    begin
                        wr_se = 1'b1; wr_ee = 1'b1; wr_oe = 1'b1; wr_ue = 1'b1;
                        wr_idx  = w_reg[IDX_W-1:0];
                        wr_used = u_eff;
                        w_next  = w_reg + 1'b1;
                        prev_used_next = u_eff;
                    end
                    idx_next = idx_reg + 1'b1;
                end
                else
                begin
                    count_next      = w_reg;
                    res_status_next = freed_reg ? ST_OK : ST_NO_RELEASE;
                    state_next      = S_DONE;
                end
            end
            S_COMPACT:
            begin
                if (idx_reg < count_reg)
                begin
                    if (rd_used)
                    begin
                        wr_se = 1'b1; wr_ee = 1'b1; wr_oe = 1'b1; wr_ue = 1'b1;
                        wr_idx   = w_reg[IDX_W-1:0];
                        wr_start = next_addr_reg[ADDR_W-1:0];
                        wr_end   = next_addr_reg[ADDR_W-1:0] + rd_span;
                        wr_used  = 1'b1;
                        next_addr_next = next_addr_reg + rd_len;
                        w_next = w_reg + 1'b1;
                    end
                    idx_next = idx_reg + 1'b1;
                end
                else
                begin
                    state_next = S_TAIL;
                end
            end
            S_TAIL:
            begin
                count_next = w_reg;
                if (next_addr_reg < mem_size_reg && w_reg < CNT_W'(MAX_SEG))
                begin
                    wr_se = 1'b1; wr_ee = 1'b1; wr_oe = 1'b1; wr_ue = 1'b1;
                    wr_idx   = w_reg[IDX_W-1:0];
                    wr_start = next_addr_reg[ADDR_W-1:0];
                    wr_end   = ADDR_W'(mem_size_reg - 1'b1);
                    wr_owner = '0;
                    wr_used  = 1'b0;
                    count_next = w_reg + 1'b1;
                end
                res_status_next = ST_OK;
                state_next      = S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= CNT_W'(1);
            mem_size_reg  <= MEM_LIMIT;
            seg_used_reg  <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < MAX_SEG; i++)
            begin
                seg_start_reg[i] <= '0;
                seg_end_reg[i]   <= '0;
            end
            seg_end_reg[0] <= ADDR_W'(MEM_LIMIT - 1'b1);
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                mem_size_reg     <= cfg_sat;
                count_reg        <= CNT_W'(1);
                seg_used_reg     <= '0;
                seg_start_reg[0] <= '0;
                seg_end_reg[0]   <= ADDR_W'(cfg_sat - 1'b1);
            end
            else
            begin
                count_reg <= count_next;
                if (wr_se)
                    seg_start_reg[wr_idx] <= wr_start;
                if (wr_ee)
                    seg_end_reg[wr_idx] <= wr_end;
                if (wr_ue)
                    seg_used_reg[wr_idx] <= wr_used;
            end
            if (state_reg == S_DONE && out_free)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_oe && !cfg_we)
            seg_owner_reg[wr_idx] <= wr_owner;
        if (in_fire)
        begin
            mode_reg <= s_axis_tdata[1:0];
            own_reg  <= s_axis_tdata[9:2];
            size_reg <= s_axis_tdata[30:10];
            pol_reg  <= s_axis_tdata[32:31];
        end
        idx_reg        <= idx_next;
        w_reg          <= w_next;
        pick_reg       <= pick_next;
        pick_start_reg <= pick_start_next;
        best_reg       <= best_next;
        found_reg      <= found_next;
        prev_used_reg  <= prev_used_next;
        freed_reg      <= freed_next;
        next_addr_reg  <= next_addr_next;
        res_status_reg <= res_status_next;
        res_base_reg   <= (mode_reg == MODE_REQUEST || state_reg == S_IDLE) ?
                          res_base_next : '0;
        if (state_reg == S_DONE && out_free)
        begin
            out_status_reg <= res_status_reg;
            out_base_reg   <= res_base_reg;
            out_count_reg  <= count_reg;
        end
    end
endmodule
`default_nettype wire

>>> dv/testbench.sv
// Self-checking testbench for contiguous_segment_allocator: streams request,
// release and compact items, predicts each result from an internal segment table.
// Depends on csa_pkg and the contiguous_segment_allocator RTL.
`default_nettype none
module testbench;
    import csa_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [1:0]  fit_policy;
        logic [20:0] request_size;
        logic [7:0]  owner_id;
        logic [1:0]  mode;
    } op_item_t;

    typedef struct packed {
        logic [4:0]  segments_in_use;
        logic [19:0] alloc_base;
        logic [2:0]  status;
    } alloc_result_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [20:0] cfg_wdata;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;

    contiguous_segment_allocator u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    // shadow segment table
    logic [19:0] seg_lo [MAX_SEG];
    logic [19:0] seg_hi [MAX_SEG];
    logic [7:0]  seg_own [MAX_SEG];
    logic        seg_busy [MAX_SEG];
    int          seg_cnt;
    logic [20:0] mem_bytes;

    op_item_t      pending_ops[$];
    alloc_result_t awaited_results[$];
    int            mismatches;
    int            results_seen;
    int            ok_grants;
    int            send_idle_pct;
    int            recv_idle_pct;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #5ms;
        $display("timeout at %0t", $realtime);
        $display("contiguous_segment_allocator verification failed");
        $finish;
    end

    function automatic void table_init(input logic [20:0] size);
        for (int i = 0; i < MAX_SEG; i++)
        begin
            seg_lo[i] = '0;
            seg_hi[i] = '0;
            seg_own[i] = '0;
            seg_busy[i] = 1'b0;
        end
        mem_bytes = size;
        seg_hi[0] = 20'(size - 21'd1);
        seg_cnt = 1;
    endfunction

    function automatic logic [20:0] hole_len(input int i);
        return 21'(seg_hi[i]) - 21'(seg_lo[i]) + 21'd1;
    endfunction

    function automatic void merge_holes();
        int w;
        w = 0;
        for (int r = 0; r < seg_cnt; r++)
        begin
            if (w > 0 && !seg_busy[r] && !seg_busy[w-1])
                seg_hi[w-1] = seg_hi[r];
            else
            begin
                seg_lo[w] = seg_lo[r];
                seg_hi[w] = seg_hi[r];
                seg_own[w] = seg_own[r];
                seg_busy[w] = seg_busy[r];
                w++;
            end
        end
        seg_cnt = w;
    endfunction

    function automatic alloc_result_t predict_alloc(input op_item_t op);
        alloc_result_t res;
        int pick;
        bit found;
        bit freed;
        logic [20:0] bestlen;
        logic [20:0] h;
        logic [20:0] next;
        int w;
        res = '0;
        if (op.mode == MODE_REQUEST)
        begin
            found = 0;
            pick = 0;
            bestlen = '0;
            if (op.fit_policy > FIT_WORST)
                res.status = ST_BAD_POLICY;
            else if (op.request_size == 0)
                res.status = ST_BAD_SIZE;
            else
            begin
                for (int i = 0; i < seg_cnt; i++)
                begin
                    h = hole_len(i);
                    if (seg_busy[i] || h < op.request_size)
                        continue;
                    if (op.fit_policy == FIT_FIRST)
                    begin
                        if (!found)
                        begin
                            found = 1;
                            pick = i;
                        end
                    end
                    else if (op.fit_policy == FIT_BEST)
                    begin
                        if (!found || h < bestlen)
                        begin
                            found = 1;
                            pick = i;
                            bestlen = h;
                        end
                    end
                    else if (!found || h > bestlen)
                    begin
                        found = 1;
                        pick = i;
                        bestlen = h;
                    end
                end
                if (!found)
                    res.status = ST_NO_HOLE;
                else if (hole_len(pick) != op.request_size && seg_cnt >= MAX_SEG)
                    res.status = ST_TABLE_FULL;
                else
                begin
                    if (hole_len(pick) != op.request_size)
                    begin
                        for (int i = seg_cnt; i > pick + 1; i--)
                        begin
                            seg_lo[i] = seg_lo[i-1];
                            seg_hi[i] = seg_hi[i-1];
                            seg_own[i] = seg_own[i-1];
                            seg_busy[i] = seg_busy[i-1];
                        end
                        seg_lo[pick+1] = seg_lo[pick] + 20'(op.request_size);
                        seg_hi[pick+1] = seg_hi[pick];
                        seg_own[pick+1] = '0;
                        seg_busy[pick+1] = 1'b0;
                        seg_hi[pick] = seg_lo[pick] + 20'(op.request_size) - 20'd1;
                        seg_cnt++;
                    end
                    seg_busy[pick] = 1'b1;
                    seg_own[pick] = op.owner_id;
                    res.status = ST_OK;
                    res.alloc_base = seg_lo[pick];
                end
            end
        end
        else if (op.mode == MODE_RELEASE)
        begin
            freed = 0;
            for (int i = 0; i < seg_cnt; i++)
                if (seg_busy[i] && seg_own[i] == op.owner_id)
                begin
                    seg_busy[i] = 1'b0;
                    freed = 1;
                end
            merge_holes();
            res.status = freed ? ST_OK : ST_NO_RELEASE;
        end
        else if (op.mode == MODE_COMPACT)
        begin
            w = 0;
            next = '0;
            for (int r = 0; r < seg_cnt; r++)
            begin
                if (!seg_busy[r])
                    continue;
                h = hole_len(r);
                seg_lo[w] = 20'(next);
                seg_hi[w] = 20'(next + h - 21'd1);
                seg_own[w] = seg_own[r];
                seg_busy[w] = 1'b1;
                next += h;
                w++;
            end
            if (next < mem_bytes && w < MAX_SEG)
            begin
                seg_lo[w] = 20'(next);
                seg_hi[w] = 20'(mem_bytes - 21'd1);
                seg_own[w] = '0;
                seg_busy[w] = 1'b0;
                w++;
            end
            seg_cnt = w;
        end
        res.segments_in_use = 5'(seg_cnt);
        return res;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("MISMATCH %0t: %s got %0d want %0d", $realtime, what, got, want);
        mismatches++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata <= '0;
        end
        else if (!s_axis_tvalid || s_axis_tready)
        begin
            if (pending_ops.size() > 0 && $urandom_range(99) >= send_idle_pct)
            begin
                s_axis_tdata <= 40'(pending_ops[0]);
                s_axis_tvalid <= 1'b1;
                awaited_results.push_back(predict_alloc(pending_ops.pop_front()));
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        alloc_result_t got;
        alloc_result_t want;
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = alloc_result_t'(m_axis_tdata[27:0]);
                results_seen++;
                if (awaited_results.size() == 0)
                    report_mismatch("unexpected results", 1, 0);
                else
                begin
                    want = awaited_results.pop_front();
                    if (got.status == ST_OK && want.alloc_base != 0)
                        ok_grants++;
                    if (got.status != want.status)
                        report_mismatch("status", int'(got.status), int'(want.status));
                    if (got.alloc_base != want.alloc_base)
                        report_mismatch("alloc_base", int'(got.alloc_base),
                                        int'(want.alloc_base));
                    if (got.segments_in_use != want.segments_in_use)
                        report_mismatch("segments_in_use", int'(got.segments_in_use),
                                        int'(want.segments_in_use));
                end
            end
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    function automatic op_item_t make_op(input logic [1:0] mode, input logic [7:0] owner,
                                         input logic [20:0] size, input logic [1:0] fit);
        op_item_t op;
        op.mode = mode;
        op.owner_id = owner;
        op.request_size = size;
        op.fit_policy = fit;
        return op;
    endfunction

    task automatic drain();
        while (pending_ops.size() > 0 || awaited_results.size() > 0 || s_axis_tvalid)
            @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    task automatic write_size(input logic [20:0] value);
        logic [20:0] v;
        drain();
        v = (value == 0) ? 21'd1 : (value > MEM_LIMIT ? MEM_LIMIT : value);
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        table_init(v);
    endtask

    // mostly sizes of 1 to span; mostly well-formed alloc/free/compact traffic with some bad items
    task automatic random_ops(input int n, input int span);
        op_item_t op;
        int pick;
        for (int k = 0; k < n; k++)
        begin
            pick = $urandom_range(99);
            op.owner_id = 8'($urandom_range(7));
            if ($urandom_range(9) == 0)
                op.owner_id = 8'($urandom);
            op.fit_policy = 2'($urandom_range(2));
            if ($urandom_range(24) == 0)
                op.fit_policy = 2'd3;
            op.request_size = 21'($urandom_range(span, 1));
            if ($urandom_range(29) == 0)
                op.request_size = 21'($urandom);
            if ($urandom_range(39) == 0)
                op.request_size = '0;
            if (pick < 60)
                op.mode = MODE_REQUEST;
            else if (pick < 88)
                op.mode = MODE_RELEASE;
            else if (pick < 97)
                op.mode = MODE_COMPACT;
            else
                op.mode = 2'd3;
            pending_ops.push_back(op);
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        mismatches = 0;
        results_seen = 0;
        ok_grants = 0;
        send_idle_pct = 16;
        recv_idle_pct = 86;
        table_init(MEM_LIMIT);
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        pending_ops.push_back(make_op(MODE_REQUEST, 8'd1, 21'd0, FIT_FIRST));
        pending_ops.push_back(make_op(MODE_REQUEST, 8'd1, 21'd16, 2'd3));
        pending_ops.push_back(make_op(MODE_REQUEST, 8'd1, 21'h1FFFFF, FIT_FIRST));
        pending_ops.push_back(make_op(MODE_REQUEST, 8'hFF, 21'd100, FIT_FIRST));
        pending_ops.push_back(make_op(MODE_REQUEST, 8'd2, 21'd50, FIT_BEST));
        pending_ops.push_back(make_op(MODE_REQUEST, 8'd3, 21'd200, FIT_WORST));
        pending_ops.push_back(make_op(MODE_RELEASE, 8'hFF, 21'd0, FIT_FIRST));
        pending_ops.push_back(make_op(MODE_RELEASE, 8'd9, 21'd0, FIT_FIRST));
        pending_ops.push_back(make_op(MODE_REQUEST, 8'd4, 21'd60, FIT_BEST));
        pending_ops.push_back(make_op(MODE_REQUEST, 8'd5, 21'd40, FIT_FIRST));
        pending_ops.push_back(make_op(MODE_COMPACT, 8'd0, 21'd0, 2'd3));
        pending_ops.push_back(make_op(2'd3, 8'hAA, 21'h155555, 2'd3));
        pending_ops.push_back(make_op(MODE_RELEASE, 8'd2, 21'd0, FIT_FIRST));
        pending_ops.push_back(make_op(MODE_RELEASE, 8'd3, 21'd0, FIT_FIRST));
        pending_ops.push_back(make_op(MODE_REQUEST, 8'd6, 21'h0FFFFF, FIT_WORST));
        pending_ops.push_back(make_op(MODE_REQUEST, 8'd7, 21'd1, FIT_BEST));
        drain();

        // fill the table with one-byte grants to hit table-full and exact-fit cases
        write_size(21'd20);
        for (int i = 0; i < 17; i++)
            pending_ops.push_back(make_op(MODE_REQUEST, 8'(i), 21'd1, FIT_FIRST));
        pending_ops.push_back(make_op(MODE_REQUEST, 8'd40, 21'd4, FIT_BEST));
        pending_ops.push_back(make_op(MODE_REQUEST, 8'd41, 21'd5, FIT_FIRST));
        drain();

        write_size(21'd0);
        random_ops(20, 2);
        write_size(21'h1FFFFF);
        random_ops(120, 70000);
        write_size(21'd300);
        random_ops(120, 40);
        // hold until everything is back
        drain();
        send_idle_pct = 86;
        recv_idle_pct = 16;
        write_size(MEM_LIMIT);
        random_ops(120, 50000);
        drain();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_size(21'd1000);
        random_ops(130, 150);
        drain();

        $display("ran %0d operations across sizes 1 to 2^20 and all three fit policies, %0d grants",
                 results_seen, ok_grants);
        if (mismatches == 0)
            $display("contiguous_segment_allocator verification clean");
        else
            $display("contiguous_segment_allocator verification failed");
        $finish;
    end
endmodule
`default_nettype wire
